[rtl/core/ptpalu_pkg.sv]
package ptpalu_pkg;

	// operation codes
	localparam logic [2:0] CMD_ADD  = 3'd0;
	localparam logic [2:0] CMD_SUB  = 3'd1;
	localparam logic [2:0] CMD_CMP  = 3'd2;
	localparam logic [2:0] CMD_DIFF = 3'd3;
	localparam logic [2:0] CMD_TMO  = 3'd4;
	localparam logic [2:0] CMD_CORR = 3'd5;
	localparam logic [2:0] CMD_POW2 = 3'd6;

	// biased numerator width and quotient bits of the ns divider
	localparam int NUM_W = 50;
	localparam int QUO_W = 20;
	localparam int QDEPTH = 4;
	localparam int QCNT_W = 3;

	// quotient estimate: (numerator >> RECIP_TAP) * RECIP_M >> RECIP_SH,
	// RECIP_M = floor(2^51 / 1e9); low by at most one
	localparam int RECIP_TAP = 29;
	localparam int RECIP_SH = 22;
	localparam logic [21:0] RECIP_M = 22'd2251799;

	localparam logic [29:0] NS_PER_S = 30'd1000000000;
	// bias keeps the numerator non-negative: BIAS_NS = BIAS_S * 1e9
	localparam logic [19:0] BIAS_S = 20'd281475;
	localparam logic [NUM_W-1:0] BIAS_NS = 50'd281475000000000;

	// front pipeline occupancy
	typedef struct packed {
		logic s1;
		logic s2;
	} fr_occ_t;

endpackage

[rtl/core/ptpalu_front.sv]
module ptpalu_front #(
	parameter int SECONDS_BITS = 48,
	parameter int QW = SECONDS_BITS + 67
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [2:0]               cmd,
	input  logic [SECONDS_BITS-1:0]  a_seconds,
	input  logic [29:0]              a_nanoseconds,
	input  logic [15:0]              a_frac,
	input  logic [SECONDS_BITS-1:0]  b_seconds,
	input  logic [29:0]              b_nanoseconds,
	input  logic [15:0]              b_frac,
	input  logic signed [63:0]       correction,
	input  logic signed [5:0]        exponent,
	output ptpalu_pkg::fr_occ_t      occ,
	output logic                     push,
	output logic [QW-1:0]            push_data
);
	import ptpalu_pkg::*;

	localparam int SB = SECONDS_BITS;

	// stage 1 registers
	logic          v_s1;
	logic [2:0]    cmd_s1;
	logic [SB-1:0] as_s1, bs_s1;
	logic [29:0]   an_s1, bn_s1;
	logic [15:0]   af_s1, bf_s1;
	logic [63:0]   corr_s1;
	logic [5:0]    exp_s1;

	// stage 2 registers
	logic          v_s2;
	logic [2:0]    cmd_s2;
	logic [SB-1:0] as_s2, bs_s2;
	logic [29:0]   an_s2, bn_s2;
	logic [15:0]   af_s2, bf_s2;
	logic [5:0]    exp_s2;
	logic          older_s2, tzero_s2;
	logic [48:0]   cn_s2;
	logic [15:0]   cf_s2;

	logic          sec_eq, older, tzero;
	logic [64:0]   ctot;

	always_comb begin
		sec_eq = (as_s1 == bs_s1);
		older = (as_s1 < bs_s1) ||
			(sec_eq && (an_s1 < bn_s1)) ||
			(sec_eq && (an_s1 == bn_s1) && (af_s1 < bf_s1));
		tzero = (as_s1 > bs_s1) || (sec_eq && (an_s1 > bn_s1));
		// subnanosecond count plus signed correction
		ctot = {19'b0, an_s1, af_s1} + {corr_s1[63], corr_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= cmd;
		as_s1   <= a_seconds;
		bs_s1   <= b_seconds;
		an_s1   <= a_nanoseconds;
		bn_s1   <= b_nanoseconds;
		af_s1   <= a_frac;
		bf_s1   <= b_frac;
		corr_s1 <= correction;
		exp_s1  <= exponent;

		cmd_s2   <= cmd_s1;
		as_s2    <= as_s1;
		bs_s2    <= bs_s1;
		an_s2    <= an_s1;
		bn_s2    <= bn_s1;
		af_s2    <= af_s1;
		bf_s2    <= bf_s1;
		exp_s2   <= exp_s1;
		older_s2 <= older;
		tzero_s2 <= tzero;
		cn_s2    <= ctot[64:16];
		cf_s2    <= ctot[15:0];
	end

	logic [SB-1:0] xs, ys, base, base_adj;
	logic [29:0]   xn, yn;
	logic [15:0]   xf, yf, frac;
	logic [16:0]   fsum, fdif;
	logic [NUM_W:0] n, numer;
	logic          flag;
	logic [5:0]    nexp;

	always_comb begin
		base = '0;
		n    = '0;
		frac = '0;
		flag = 1'b0;
		// difference takes the later minus the earlier
		if (cmd_s2 == CMD_DIFF && older_s2) begin
			xs = bs_s2; xn = bn_s2; xf = bf_s2;
			ys = as_s2; yn = an_s2; yf = af_s2;
		end else begin
			xs = as_s2; xn = an_s2; xf = af_s2;
			ys = bs_s2; yn = bn_s2; yf = bf_s2;
		end
		fsum = {1'b0, af_s2} + {1'b0, bf_s2};
		fdif = {1'b0, xf} - {1'b0, yf};
		nexp = 6'(-exp_s2);
		unique case (cmd_s2)
			CMD_ADD: begin
				base = as_s2 + bs_s2;
				n = {21'b0, an_s2} + {21'b0, bn_s2} + {50'b0, fsum[16]};
				frac = fsum[15:0];
			end
			CMD_SUB, CMD_DIFF: begin
				base = xs - ys;
				n = {21'b0, xn} - {21'b0, yn} - {50'b0, fdif[16]};
				frac = fdif[15:0];
				flag = (cmd_s2 == CMD_DIFF) && !older_s2;
			end
			CMD_CMP: begin
				flag = older_s2;
			end
			CMD_TMO: begin
				if (!tzero_s2) begin
					base = bs_s2 - as_s2;
					n = {21'b0, bn_s2} - {21'b0, an_s2};
				end
			end
			CMD_CORR: begin
				base = as_s2;
				n = {{2{cn_s2[48]}}, cn_s2};
				frac = cf_s2;
			end
			CMD_POW2: begin
				if (exp_s2 == 6'd0) begin
					base = SB'(1);
				end else if (!exp_s2[5]) begin
					base = SB'(1) << exp_s2[4:0];
				end else begin
					n = {21'b0, NS_PER_S >> nexp};
				end
			end
			default: begin
			end
		endcase
		numer = n + {1'b0, BIAS_NS};
		base_adj = base - SB'(BIAS_S);
	end

	assign push      = v_s2;
	assign push_data = {base_adj, numer[NUM_W-1:0], frac, flag};
	assign occ.s1    = v_s1;
	assign occ.s2    = v_s2;

endmodule

[rtl/core/ptpalu_queue.sv]
module ptpalu_queue #(
	parameter int W = 115
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [W-1:0]                wr_data,
	output logic                        rd_valid,
	output logic [W-1:0]                rd_data,
	output logic [ptpalu_pkg::QCNT_W-1:0] count
);
	import ptpalu_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	logic [W-1:0]      mem [QDEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;

	// back end is always ready
	assign pop      = (cnt_q != '0);
	assign rd_valid = pop;
	assign rd_data  = mem[rd_ptr_q];
	assign count    = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q != QCNT_W'(QDEPTH))
		else $error("queue overflow");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
		else $error("queue count did not advance");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != QCNT_W'(QDEPTH) |-> PW'(wr_ptr_q - rd_ptr_q) == cnt_q[PW-1:0])
		else $error("queue pointers out of step");

endmodule

[rtl/core/ptpalu_back.sv]
module ptpalu_back #(
	parameter int SECONDS_BITS = 48,
	parameter int QW = SECONDS_BITS + 67
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [QW-1:0]           in_data,
	output logic                    done,
	output logic [SECONDS_BITS-1:0] res_seconds,
	output logic [29:0]             res_nanoseconds,
	output logic [15:0]             res_frac,
	output logic                    flag
);
	import ptpalu_pkg::*;

	localparam int SB = SECONDS_BITS;

	// divide by 1e9 with a reciprocal estimate and one correction step
	logic             v_s1, v_s2, v_s3;
	logic [SB-1:0]    base_s1, base_s2, base_s3;
	logic [NUM_W-1:0] num_s1;
	logic [31:0]      nlo_s2, rem_s3;
	logic [QUO_W-1:0] quo_s2, quo_s3;
	logic [15:0]      frac_s1, frac_s2, frac_s3;
	logic             flag_s1, flag_s2, flag_s3;

	logic             done_q;
	logic [SB-1:0]    sec_q;
	logic [29:0]      ns_q;
	logic [15:0]      fr_q;
	logic             fl_q;

	logic [42:0]      prod;
	logic [31:0]      qmul;

	always_comb begin
		prod = {22'b0, num_s1[NUM_W-1:RECIP_TAP]} * {21'b0, RECIP_M};
		// remainder fits in 31 bits, so the low 32 bits are enough
		qmul = {12'b0, quo_s2} * {2'b0, NS_PER_S};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		{base_s1, num_s1, frac_s1, flag_s1} <= in_data;

		quo_s2  <= QUO_W'(prod >> RECIP_SH);
		nlo_s2  <= num_s1[31:0];
		base_s2 <= base_s1;
		frac_s2 <= frac_s1;
		flag_s2 <= flag_s1;

		rem_s3  <= nlo_s2 - qmul;
		quo_s3  <= quo_s2;
		base_s3 <= base_s2;
		frac_s3 <= frac_s2;
		flag_s3 <= flag_s2;

		// base already carries minus the bias
		if (rem_s3 >= {2'b0, NS_PER_S}) begin
			sec_q <= base_s3 + SB'(quo_s3) + SB'(1);
			ns_q  <= 30'(rem_s3 - {2'b0, NS_PER_S});
		end else begin
			sec_q <= base_s3 + SB'(quo_s3);
			ns_q  <= rem_s3[29:0];
		end
		fr_q <= frac_s3;
		fl_q <= flag_s3;
	end

	assign done            = done_q;
	assign res_seconds     = sec_q;
	assign res_nanoseconds = ns_q;
	assign res_frac        = fr_q;
	assign flag            = fl_q;

endmodule

[rtl/core/ptp_timestamp_alu_top.sv]
// ptp timestamp alu: add, subtract, compare, difference, timeout, correction, 2^n interval
// path: a word taken at a clock edge passes two front stages, the queue, the back stages
// s1, s2 and s3, and one output register before it shows on the result ports
// throughput: one word per cycle while busy is low; the reciprocal ns divider is fully pipelined
// reset: arst_n clears all valid flags and the queue; payload registers are not reset
// results cannot be stalled: done is a one-cycle strobe with the result beside it
module ptp_timestamp_alu_top #(
	parameter int SECONDS_BITS = 48
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              cmd,
	input  logic [SECONDS_BITS-1:0] a_seconds,
	input  logic [29:0]             a_nanoseconds,
	input  logic [15:0]             a_frac,
	input  logic [SECONDS_BITS-1:0] b_seconds,
	input  logic [29:0]             b_nanoseconds,
	input  logic [15:0]             b_frac,
	input  logic signed [63:0]      correction,
	input  logic signed [5:0]       exponent,
	output logic                    done,
	output logic [SECONDS_BITS-1:0] res_seconds,
	output logic [29:0]             res_nanoseconds,
	output logic [15:0]             res_frac,
	output logic                    flag
);
	import ptpalu_pkg::*;

	// queue word: base seconds minus bias, biased ns numerator, frac, flag
	localparam int QW = SECONDS_BITS + NUM_W + 17;
	// cycles from accept edge to the edge that samples done
	localparam int LAT = 7;

	logic              accept;
	fr_occ_t           occ;
	logic              push;
	logic [QW-1:0]     push_data;
	logic              q_valid;
	logic [QW-1:0]     q_data;
	logic [QCNT_W-1:0] q_count;
	logic [QCNT_W:0]   in_flight;

	assign accept = start && !busy;

	// credit check: queued words plus those still in the front must fit
	assign in_flight = {1'b0, q_count} + (QCNT_W+1)'(occ.s1) + (QCNT_W+1)'(occ.s2);
	assign busy      = in_flight >= (QCNT_W+1)'(QDEPTH);

	// front: register, classify (older, timeout sign, correction sum),
	// then form seconds base and signed ns numerator
	ptpalu_front #(
		.SECONDS_BITS(SECONDS_BITS),
		.QW(QW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(accept),
		.cmd(cmd),
		.a_seconds(a_seconds),
		.a_nanoseconds(a_nanoseconds),
		.a_frac(a_frac),
		.b_seconds(b_seconds),
		.b_nanoseconds(b_nanoseconds),
		.b_frac(b_frac),
		.correction(correction),
		.exponent(exponent),
		.occ(occ),
		.push(push),
		.push_data(push_data)
	);

	// short queue decouples front and back
	ptpalu_queue #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(push_data),
		.rd_valid(q_valid),
		.rd_data(q_data),
		.count(q_count)
	);

	// back: floor-divide the ns numerator by 1e9 and fold the quotient into seconds
	ptpalu_back #(
		.SECONDS_BITS(SECONDS_BITS),
		.QW(QW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(q_valid),
		.in_data(q_data),
		.done(done),
		.res_seconds(res_seconds),
		.res_nanoseconds(res_nanoseconds),
		.res_frac(res_frac),
		.flag(flag)
	);

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("result missing after fixed latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a word taken");

	a_ns_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res_nanoseconds < NS_PER_S)
		else $error("nanoseconds not normalized");

endmodule
